/* rtl/core/wpd_pkg.sv */
// Package for the WAV PCM stream decoder: RIFF tags, status and result codes,
// and the result layout. No dependencies.
`default_nettype none

package wpd_pkg;

  // Little-endian four-character tags as they assemble from the byte stream
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;

  // End-of-file status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_RIFF   = 3'd1;
  localparam logic [2:0] ST_SIZE      = 3'd2;
  localparam logic [2:0] ST_NO_WAVE   = 3'd3;
  localparam logic [2:0] ST_NOT_PCM   = 3'd4;
  localparam logic [2:0] ST_BAD_WIDTH = 3'd5;
  localparam logic [2:0] ST_DATA_EARLY = 3'd6;

  // Result kinds carried on tuser
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Result tdata layout
  localparam int unsigned OUT_W     = 88;
  localparam int unsigned OUT_ST_LO = 32;
  localparam int unsigned OUT_BPS_LO = 83;

  // Divider width (block align / channels)
  localparam int unsigned DIV_W = 16;

endpackage

`default_nettype wire

/* rtl/core/wpd_div.sv */
// Restoring divider, one quotient bit per cycle, for block align / channels.
// Depends on wpd_pkg.
`default_nettype none

module wpd_div
  import wpd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DIV_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DIV_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic                     busy_q;
  logic                     done_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [DIV_W-1:0]         rem_q, rem_d;
  logic [DIV_W-1:0]         quo_q, quo_d;
  logic [DIV_W-1:0]         dvs_q;
  logic [DIV_W:0]           shifted;
  logic [DIV_W-1:0]         trial;

  // One trial subtract per cycle; the difference fits when the compare passes
  always_comb begin
    shifted = {rem_q, quo_q[DIV_W-1]};
    trial   = shifted[DIV_W-1:0] - dvs_q;
    if (shifted >= {1'b0, dvs_q}) begin
      rem_d = trial;
      quo_d = {quo_q[DIV_W-2:0], 1'b1};
    end else begin
      rem_d = shifted[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

/* rtl/core/wav_pcm_stream_decoder.sv */
// WAV PCM stream decoder top level: byte sequencer, RIFF chunk walker and
// sample formatter. Depends on wpd_pkg and wpd_div.
//
//  channel | dir | tdata                 | tlast        | tuser
//  --------+-----+-----------------------+--------------+-----------------
//  s_axis  | in  | file_byte             | end_of_file  | -
//  m_axis  | out | sample,status,chan,   | last_result  | kind (0 sample,
//          |     | rate,bytes_per_sample |              |  1 report)
//
// Sequence: each file byte is accepted, then takes one processing step. The
// byte that closes a fmt chunk adds a format check and, if that passes, a run
// of the bit-serial divider for block align / channels, a wait for its result
// and a width check. The end-of-file byte adds a report step.
// Reset returns the parser to the RIFF tag phase; it also restarts there after
// every report. A full output register stalls a sample or report step until
// the downstream side takes the pending transaction.
`default_nettype none

module wav_pcm_stream_decoder
  import wpd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Input bytes
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,   // [7:0] file_byte
  input  wire logic             s_axis_tlast,   // end_of_file
  // Results
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [OUT_W-1:0] m_axis_tdata,   // [31:0] sample, [34:32] status,
                                                // [50:35] channels,
                                                // [82:51] sample_rate,
                                                // [85:83] bytes_per_sample,
                                                // [87:86] zero
  output logic                  m_axis_tuser,   // kind
  output logic                  m_axis_tlast    // last_result
);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STEP   = 3'd1;
  localparam logic [2:0] S_FMTEND = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DIVEND = 3'd4;
  localparam logic [2:0] S_REPORT = 3'd5;

  // Parse phases
  localparam logic [3:0] PH_RIFF = 4'd0;
  localparam logic [3:0] PH_SIZE = 4'd1;
  localparam logic [3:0] PH_WAVE = 4'd2;
  localparam logic [3:0] PH_HDR  = 4'd3;
  localparam logic [3:0] PH_DATA = 4'd4;
  localparam logic [3:0] PH_FMT  = 4'd5;
  localparam logic [3:0] PH_SKIP = 4'd6;
  localparam logic [3:0] PH_PAD  = 4'd7;
  localparam logic [3:0] PH_DONE = 4'd8;

  localparam logic [32:0] SEEN_MAX  = '1;
  localparam logic [33:0] TOTAL_RST = 34'd8;   // declared size zero plus header

  logic [2:0]       seq_q, seq_d;
  logic [3:0]       phase_q, phase_d;
  logic [2:0]       idx_q, idx_d;
  logic [31:0]      fs_q, fs_d;        // little-endian field being assembled
  logic [33:0]      total_q, total_d;  // declared RIFF size + 8
  logic [32:0]      seen_q, seen_d;
  logic [31:0]      tag_q, tag_d;
  logic [31:0]      left_q, left_d;
  logic [15:0]      chan_q, chan_d;
  logic [31:0]      rate_q, rate_d;
  logic [15:0]      align_q, align_d;
  logic [2:0]       width_q, width_d;
  logic [23:0]      asm_q, asm_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [2:0]       err_q, err_d;
  logic [4:0]       foff_q, foff_d;
  logic [7:0]       byte_q;
  logic             eof_q;
  logic             ovalid_q, ovalid_d;
  logic             okind_q, okind_d;
  logic             olast_q, olast_d;
  logic [OUT_W-1:0] odata_q, odata_d;

  logic             accept;
  logic             out_free;
  logic [31:0]      fs_new;
  logic [31:0]      left_dec;
  logic [31:0]      fit_opnd;
  logic [33:0]      fit_sum;
  logic             fit_over;
  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;
  logic [31:0]      smp;
  logic [2:0]       status;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;

  // Merge the held byte into the field at the current byte lane
  assign fs_new   = fs_q | ({24'd0, byte_q} << {idx_q[1:0], 3'b000});
  assign left_dec = left_q - 32'd1;

  // Shared fit compare: does seen + operand run past the declared file end?
  // At a nonzero chunk size it checks the chunk; otherwise it checks room for a header.
  always_comb begin
    fit_opnd = 32'd8;
    if (seq_q == S_STEP && phase_q == PH_HDR && idx_q == 3'd7 && fs_new != 32'd0) begin
      fit_opnd = fs_new;
    end
  end
  assign fit_sum  = {1'b0, seen_q} + {2'b00, fit_opnd};
  assign fit_over = fit_sum > total_q;

  // Left-justify the finished sample; 8-bit data is offset binary
  always_comb begin
    unique case (width_q)
      3'd1:    smp = {byte_q ^ 8'h80, 24'd0};
      3'd2:    smp = {byte_q, asm_q[7:0], 16'd0};
      3'd3:    smp = {byte_q, asm_q[15:0], 8'd0};
      default: smp = {byte_q, asm_q[23:0]};
    endcase
  end

  // Report status: a missing RIFF ranks first, then a size mismatch
  always_comb begin
    priority if (err_q == ST_NO_RIFF || phase_q == PH_RIFF) begin
      status = ST_NO_RIFF;
    end else if (phase_q == PH_SIZE || {1'b0, seen_q} != total_q) begin
      status = ST_SIZE;
    end else if (err_q == ST_NO_WAVE || phase_q == PH_WAVE) begin
      status = ST_NO_WAVE;
    end else begin
      status = err_q;
    end
  end

  wpd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (align_q),
    .divisor_i  (chan_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    seq_d     = seq_q;
    phase_d   = phase_q;
    idx_d     = idx_q;
    fs_d      = fs_q;
    total_d   = total_q;
    seen_d    = seen_q;
    tag_d     = tag_q;
    left_d    = left_q;
    chan_d    = chan_q;
    rate_d    = rate_q;
    align_d   = align_q;
    width_d   = width_q;
    asm_d     = asm_q;
    cnt_d     = cnt_q;
    err_d     = err_q;
    foff_d    = foff_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    okind_d   = okind_q;
    olast_d   = olast_q;
    odata_d   = odata_q;
    div_start = 1'b0;

    unique case (seq_q)
      S_IDLE: begin
        if (accept) begin
          // Count the byte now; the step sees it as already seen
          if (seen_q != SEEN_MAX) begin
            seen_d = seen_q + 33'd1;
          end
          seq_d = S_STEP;
        end
      end

      S_STEP: begin
        if (!(phase_q == PH_DATA && !out_free)) begin
          seq_d = eof_q ? S_REPORT : S_IDLE;
          unique case (phase_q)
            PH_RIFF, PH_SIZE, PH_WAVE: begin
              fs_d  = fs_new;
              idx_d = idx_q + 3'd1;
              if (idx_q == 3'd3) begin
                idx_d = '0;
                fs_d  = '0;
                if (phase_q == PH_RIFF) begin
                  if (fs_new != TAG_RIFF) begin
                    phase_d = PH_DONE;
                    err_d   = ST_NO_RIFF;
                  end else begin
                    phase_d = PH_SIZE;
                  end
                end else if (phase_q == PH_SIZE) begin
                  total_d = {2'b00, fs_new} + TOTAL_RST;
                  phase_d = PH_WAVE;
                end else if (fs_new != TAG_WAVE) begin
                  phase_d = PH_DONE;
                  err_d   = ST_NO_WAVE;
                end else begin
                  phase_d = fit_over ? PH_DONE : PH_HDR;
                end
              end
            end

            PH_HDR: begin
              fs_d = fs_new;
              if (idx_q == 3'd3) begin
                tag_d = fs_new;
                fs_d  = '0;
                idx_d = 3'd4;
              end else if (idx_q == 3'd7) begin
                left_d = fs_new;
                idx_d  = '0;
                priority if (fs_new != 32'd0 && fit_over) begin
                  // Oversized chunk: stop quietly
                  phase_d = PH_DONE;
                end else if (tag_q == TAG_DATA) begin
                  if (width_q == 3'd0) begin
                    phase_d = PH_DONE;
                    err_d   = ST_DATA_EARLY;
                  end else begin
                    asm_d = '0;
                    cnt_d = '0;
                    if (fs_new == 32'd0) begin
                      fs_d    = '0;
                      phase_d = fit_over ? PH_DONE : PH_HDR;
                    end else begin
                      phase_d = PH_DATA;
                    end
                  end
                end else if (tag_q == TAG_FMT) begin
                  chan_d  = '0;
                  rate_d  = '0;
                  align_d = '0;
                  foff_d  = '0;
                  fs_d    = '0;
                  if (fs_new == 32'd0) begin
                    // Empty fmt has format code zero
                    phase_d = PH_DONE;
                    err_d   = ST_NOT_PCM;
                  end else begin
                    phase_d = PH_FMT;
                  end
                end else if (fs_new == 32'd0) begin
                  fs_d    = '0;
                  phase_d = fit_over ? PH_DONE : PH_HDR;
                end else begin
                  phase_d = PH_SKIP;
                end
              end else begin
                idx_d = idx_q + 3'd1;
              end
            end

            PH_DATA: begin
              left_d = left_dec;
              if ({1'b0, cnt_q} + 3'd1 >= width_q) begin
                ovalid_d = 1'b1;
                okind_d  = KIND_SAMPLE;
                olast_d  = 1'b0;
                odata_d  = {2'b00, width_q, rate_q, chan_q, ST_OK, smp};
                asm_d    = '0;
                cnt_d    = '0;
              end else begin
                unique case (cnt_q)
                  2'd0:    asm_d[7:0]   = byte_q;
                  2'd1:    asm_d[15:8]  = byte_q;
                  default: asm_d[23:16] = byte_q;
                endcase
                cnt_d = cnt_q + 2'd1;
              end
              if (left_dec == 32'd0) begin
                // Odd chunk size: skip one pad byte
                if (fs_q[0]) begin
                  phase_d = PH_PAD;
                end else begin
                  idx_d   = '0;
                  fs_d    = '0;
                  phase_d = fit_over ? PH_DONE : PH_HDR;
                end
              end
            end

            PH_FMT: begin
              unique case (foff_q)
                5'd0:  fs_d[7:0]      = byte_q;
                5'd1:  fs_d[15:8]     = byte_q;
                5'd2:  chan_d[7:0]    = byte_q;
                5'd3:  chan_d[15:8]   = byte_q;
                5'd4:  rate_d[7:0]    = byte_q;
                5'd5:  rate_d[15:8]   = byte_q;
                5'd6:  rate_d[23:16]  = byte_q;
                5'd7:  rate_d[31:24]  = byte_q;
                5'd12: align_d[7:0]   = byte_q;
                5'd13: align_d[15:8]  = byte_q;
                default: ;
              endcase
              if (foff_q != 5'd16) begin
                foff_d = foff_q + 5'd1;
              end
              left_d = left_dec;
              if (left_dec == 32'd0) begin
                seq_d = S_FMTEND;
              end
            end

            PH_SKIP: begin
              left_d = left_dec;
              if (left_dec == 32'd0) begin
                idx_d   = '0;
                fs_d    = '0;
                phase_d = fit_over ? PH_DONE : PH_HDR;
              end
            end

            PH_PAD: begin
              idx_d   = '0;
              fs_d    = '0;
              phase_d = fit_over ? PH_DONE : PH_HDR;
            end

            default: ;
          endcase
        end
      end

      S_FMTEND: begin
        seq_d = eof_q ? S_REPORT : S_IDLE;
        priority if (fs_q[15:0] != 16'd1) begin
          phase_d = PH_DONE;
          err_d   = ST_NOT_PCM;
        end else if (chan_q == 16'd0) begin
          width_d = '0;
          phase_d = PH_DONE;
          err_d   = ST_BAD_WIDTH;
        end else begin
          div_start = 1'b1;
          seq_d     = S_DIV;
        end
      end

      S_DIV: begin
        if (div_done) begin
          seq_d = S_DIVEND;
        end
      end

      S_DIVEND: begin
        seq_d = eof_q ? S_REPORT : S_IDLE;
        if (div_quot >= 16'd1 && div_quot <= 16'd4) begin
          width_d = div_quot[2:0];
          idx_d   = '0;
          fs_d    = '0;
          phase_d = fit_over ? PH_DONE : PH_HDR;
        end else begin
          width_d = '0;
          phase_d = PH_DONE;
          err_d   = ST_BAD_WIDTH;
        end
      end

      S_REPORT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          okind_d  = KIND_REPORT;
          olast_d  = 1'b1;
          odata_d  = {2'b00, width_q, rate_q, chan_q, status, 32'd0};
          // Restart for the next file
          phase_d  = PH_RIFF;
          idx_d    = '0;
          fs_d     = '0;
          total_d  = TOTAL_RST;
          seen_d   = '0;
          tag_d    = '0;
          left_d   = '0;
          chan_d   = '0;
          rate_d   = '0;
          align_d  = '0;
          width_d  = '0;
          asm_d    = '0;
          cnt_d    = '0;
          err_d    = ST_OK;
          foff_d   = '0;
          seq_d    = S_IDLE;
        end
      end

      default: seq_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q    <= S_IDLE;
      phase_q  <= PH_RIFF;
      idx_q    <= '0;
      fs_q     <= '0;
      total_q  <= TOTAL_RST;
      seen_q   <= '0;
      tag_q    <= '0;
      left_q   <= '0;
      chan_q   <= '0;
      rate_q   <= '0;
      align_q  <= '0;
      width_q  <= '0;
      asm_q    <= '0;
      cnt_q    <= '0;
      err_q    <= ST_OK;
      foff_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      seq_q    <= seq_d;
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      fs_q     <= fs_d;
      total_q  <= total_d;
      seen_q   <= seen_d;
      tag_q    <= tag_d;
      left_q   <= left_d;
      chan_q   <= chan_d;
      rate_q   <= rate_d;
      align_q  <= align_d;
      width_q  <= width_d;
      asm_q    <= asm_d;
      cnt_q    <= cnt_d;
      err_q    <= err_d;
      foff_q   <= foff_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload: held input byte and output register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= s_axis_tdata;
      eof_q  <= s_axis_tlast;
    end
    okind_q <= okind_d;
    olast_q <= olast_d;
    odata_q <= odata_d;
  end

  assign s_axis_tready = (seq_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;

endmodule

`default_nettype wire

/* rtl/core/wpd_checker.sv */
// Port-level checks for the WAV PCM stream decoder, bound to the top level.
// Depends on wpd_pkg and wav_pcm_stream_decoder.
`default_nettype none

module wpd_checker
  import wpd_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata,
  input wire logic             m_axis_tuser,
  input wire logic             m_axis_tlast
);

  // One byte at a time: ready drops right after a transaction
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a byte is still in work");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Only the report closes a file
  a_last_is_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_REPORT)))
    else $error("tlast and result kind disagree");

  // Samples carry ok status, reported widths stay in range
  a_sample_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_SAMPLE)
      |-> (m_axis_tdata[OUT_ST_LO +: 3] == ST_OK)
        && (m_axis_tdata[OUT_BPS_LO +: 3] != 3'd0))
    else $error("sample with error status or no width");

  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_BPS_LO +: 3] <= 3'd4)
    else $error("bytes per sample out of range");

endmodule

bind wav_pcm_stream_decoder wpd_checker u_wpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
